### rtl/fte_pkg.sv
`default_nettype none
package fte_pkg;
    localparam logic [2:0] REQ_GET  = 3'd0;
    localparam logic [2:0] REQ_SET  = 3'd1;
    localparam logic [2:0] REQ_ALLOC = 3'd2;
    localparam logic [2:0] REQ_LOAD = 3'd3;
    localparam logic [2:0] REQ_READ = 3'd4;

    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [1:0] REG_KIND  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_SPC   = 2'd2;
    localparam logic [1:0] REG_FDS   = 2'd3;

    localparam logic [27:0] EOC12 = 28'h0000ff8;
    localparam logic [27:0] EOC16 = 28'h000fff8;
    localparam logic [27:0] EOC32 = 28'hffffff8;
    localparam logic [27:0] MASK28 = 28'hfffffff;

    // controller -> datapath commands
    typedef struct packed {
        logic latch;      // capture request fields
        logic clr_acc;    // clear entry accumulator
        logic rd_issue;   // issue read of current byte
        logic rd_take;    // merge returned byte into accumulator
        logic wr_issue;   // write current byte of the new entry
        logic next_byte;  // advance byte counter
        logic next_clus;  // advance search cluster
        logic alloc_init; // set search start
        logic mult_go;    // register sector product
        logic finish;     // form result
    } fte_cmd_t;

    typedef struct packed {
        logic in_range;   // entry fits in image
        logic last_byte;  // current byte is the last of the entry
        logic entry_zero; // accumulated entry is zero
        logic search_done;// all clusters checked
        logic search_void;// nothing to search
    } fte_sts_t;
endpackage
`default_nettype wire

### rtl/fat_table_entry_engine_top.sv
`default_nettype none
// FAT entry engine.
// Input channel s_*: one request per valid/ready handshake (get, set,
// allocate, load byte, read byte). Result channel m_*: exactly one result
// per request, held until m_ready.
// Configuration: APB read and write, pready always high; registers at 4*i:
// fat_kind, cluster_count, sectors_per_cluster, first_data_sector.
// Load the byte image with load-byte requests before entry requests.
// Sequencing: raw byte requests pass through S_RAW and S_RAWW. Get reads each
// entry byte (issue, wait, take), then forms the data sector and the result;
// set reads the entry the same way and then writes each byte of the new entry.
// Allocate scans one entry at a time, reading each entry's bytes, until it
// finds a zero entry or has checked the whole search span.
// One request is in flight at a time; the controller accepts only when idle.
// Reset: registers return to FAT16, 4096 clusters, 1 sector per cluster,
// first data sector 0; the free hint returns to 2. The image is not
// cleared. A stalled receiver holds the result and the block accepts no
// further request until it is taken.
module fat_table_entry_engine_top #(
    parameter int TABLE_BYTES = 16384
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [27:0] s_index,
    input  wire logic [27:0] s_value,
    input  wire logic [13:0] s_byte_addr,
    input  wire logic [7:0]  s_byte_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [27:0]      m_entry_value,
    output logic             m_end_of_chain,
    output logic [27:0]      m_free_cluster,
    output logic [31:0]      m_data_sector,
    output logic [7:0]       m_byte_out,
    output logic [1:0]       m_status
);
    import fte_pkg::*;

    logic [1:0]  kind_reg;
    logic [27:0] count_reg;
    logic [7:0]  spc_reg;
    logic [31:0] fds_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en = psel && penable && pwrite;

    // hold register values; take a write at the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_FAT16;
            count_reg <= 28'd4096;
            spc_reg <= 8'd1;
            fds_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_KIND:  kind_reg <= pwdata[1:0];
                REG_COUNT: count_reg <= pwdata[27:0];
                REG_SPC:   spc_reg <= pwdata[7:0];
                REG_FDS:   fds_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_KIND:  prdata = {30'b0, kind_reg};
            REG_COUNT: prdata = {4'b0, count_reg};
            REG_SPC:   prdata = {24'b0, spc_reg};
            REG_FDS:   prdata = fds_reg;
            default:   prdata = '0;
        endcase
    end

    fte_cmd_t cmd;
    fte_sts_t sts;

    fte_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .sts(sts)
    );

    fte_dp #(.TABLE_BYTES(TABLE_BYTES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .fat_kind(kind_reg), .cluster_count(count_reg),
        .sectors_per_cluster(spc_reg), .first_data_sector(fds_reg),
        .s_req_type(s_req_type), .s_index(s_index), .s_value(s_value),
        .s_byte_addr(s_byte_addr), .s_byte_data(s_byte_data),
        .m_entry_value(m_entry_value), .m_end_of_chain(m_end_of_chain),
        .m_free_cluster(m_free_cluster), .m_data_sector(m_data_sector),
        .m_byte_out(m_byte_out), .m_status(m_status)
    );

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result without work");
    a_ready_low_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("accept while result pending");
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready) else $error("pready low");
`endif
endmodule
`default_nettype wire

### rtl/fte_ram.sv
`default_nettype none
module fte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/fte_ctrl.sv
`default_nettype none
module fte_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_req_type,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fte_pkg::fte_cmd_t       cmd,
    input  wire fte_pkg::fte_sts_t  sts
);
    import fte_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_RWAIT  = 4'd3;
    localparam logic [3:0] S_RTAKE  = 4'd4;
    localparam logic [3:0] S_WR     = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_RAW    = 4'd10;
    localparam logic [3:0] S_RAWW   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] req_reg, req_next;
    logic       mv_reg, mv_next;

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        req_next = req_reg;
        mv_next = mv_reg;
        cmd = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.latch = 1'b1;
                    req_next = s_req_type;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                cmd.clr_acc = 1'b1;
                if (req_reg == REQ_GET || req_reg == REQ_SET) begin
                    state_next = sts.in_range ? S_RD : S_MUL;
                end else if (req_reg == REQ_ALLOC) begin
                    cmd.alloc_init = 1'b1;
                    state_next = S_CHECK;
                end else if (req_reg == REQ_LOAD || req_reg == REQ_READ) begin
                    state_next = S_RAW;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_CHECK: begin
                // search loop head: stop when exhausted, else read an in-range entry or skip to the next cluster
                cmd.clr_acc = 1'b1;
                if (sts.search_void || sts.search_done) begin
                    state_next = S_FIN;
                end else begin
                    state_next = sts.in_range ? S_RD : S_CHECK;
                    cmd.next_clus = !sts.in_range;
                end
            end
            S_RD: begin
                cmd.rd_issue = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT: begin
                state_next = S_RTAKE;
            end
            S_RTAKE: begin
                cmd.rd_take = 1'b1;
                if (!sts.last_byte) begin
                    cmd.next_byte = 1'b1;
                    state_next = S_RD;
                end else if (req_reg == REQ_SET) begin
                    state_next = S_WR;
                end else if (req_reg == REQ_ALLOC) begin
                    state_next = S_MUL;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_WR: begin
                cmd.wr_issue = 1'b1;
                if (sts.last_byte) begin
                    state_next = S_MUL;
                end else begin
                    cmd.next_byte = 1'b1;
                end
            end
            S_MUL: begin
                if (req_reg == REQ_ALLOC && !sts.entry_zero) begin
                    cmd.next_clus = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    cmd.mult_go = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_RAW: begin
                state_next = S_RAWW;
            end
            S_RAWW: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!mv_reg) begin
                    cmd.finish = 1'b1;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            req_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            req_reg <= req_next;
            mv_reg <= mv_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("accept while busy");
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !mv_reg) else $error("result overwritten");
    a_idle_after: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (state_reg == S_IDLE) && mv_reg) else $error("finish flow");
`endif
endmodule
`default_nettype wire

### rtl/fte_dp.sv
`default_nettype none
module fte_dp #(
    parameter int TABLE_BYTES = 16384,
    localparam int AW = $clog2(TABLE_BYTES)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire fte_pkg::fte_cmd_t  cmd,
    output fte_pkg::fte_sts_t       sts,
    input  wire logic [1:0]         fat_kind,
    input  wire logic [27:0]        cluster_count,
    input  wire logic [7:0]         sectors_per_cluster,
    input  wire logic [31:0]        first_data_sector,
    input  wire logic [2:0]         s_req_type,
    input  wire logic [27:0]        s_index,
    input  wire logic [27:0]        s_value,
    input  wire logic [13:0]        s_byte_addr,
    input  wire logic [7:0]         s_byte_data,
    output logic [27:0]             m_entry_value,
    output logic                    m_end_of_chain,
    output logic [27:0]             m_free_cluster,
    output logic [31:0]             m_data_sector,
    output logic [7:0]              m_byte_out,
    output logic [1:0]              m_status
);
    import fte_pkg::*;

    logic [2:0]  req_reg;
    logic [27:0] idx_reg, val_reg, clus_reg;
    logic [13:0] baddr_reg;
    logic [7:0]  bdata_reg;
    logic [31:0] acc_reg;
    logic [1:0]  bcnt_reg;
    logic [27:0] start_reg, top_reg, left_reg;
    logic [31:0] sec_reg;
    logic        found_reg;
    logic [27:0] hint_reg;

    // current cluster: index for get/set, search cursor for allocate
    logic [27:0] cur;
    assign cur = (req_reg == REQ_ALLOC) ? clus_reg : idx_reg;

    logic [30:0] offs;
    logic [2:0]  span;
    always_comb begin
        unique case (fat_kind)
            KIND_FAT12: begin offs = ({3'b0, cur} + {4'b0, cur[27:1]}); span = 3'd2; end
            KIND_FAT16: begin offs = {2'b0, cur, 1'b0}; span = 3'd2; end
            default:    begin offs = {1'b0, cur, 2'b0}; span = 3'd4; end
        endcase
    end
    logic [31:0] offs_end;
    assign offs_end = {1'b0, offs} + {29'b0, span};
    logic kind_ok;
    assign kind_ok = (fat_kind != 2'd3);

    assign sts.in_range = !kind_ok ? (req_reg != REQ_ALLOC)
                        : (offs_end <= 32'(TABLE_BYTES));
    assign sts.last_byte = ({1'b0, bcnt_reg} == span - 3'd1);
    assign sts.search_done = (left_reg == '0);
    assign sts.search_void = !kind_ok || (top_reg <= 28'd2);

    // entry decode from accumulated bytes
    logic [27:0] entry;
    always_comb begin
        unique case (fat_kind)
            KIND_FAT12: entry = cur[0] ? {16'b0, acc_reg[15:4]}
                                       : {16'b0, acc_reg[11:0]};
            KIND_FAT16: entry = {12'b0, acc_reg[15:0]};
            KIND_FAT32: entry = acc_reg[27:0] & MASK28;
            default:    entry = 28'd1;
        endcase
    end
    assign sts.entry_zero = (entry == '0);

    // memory
    logic [AW-1:0] byte_ptr;
    logic [AW-1:0] raddr, waddr;
    logic [7:0]    rdata, wdata;
    logic          we;
    logic          raw_ok;
    assign byte_ptr = AW'(offs) + AW'(bcnt_reg);
    assign raw_ok = ({18'b0, baddr_reg} < 32'(TABLE_BYTES));
    assign raddr = (req_reg == REQ_READ) ? AW'(baddr_reg) : byte_ptr;

    logic [7:0] old_b, new_b;
    assign old_b = acc_reg[8*bcnt_reg +: 8];
    logic [31:0] v12;
    always_comb begin
        v12 = {4'b0, val_reg};
        new_b = v12[8*bcnt_reg +: 8];
        unique case (fat_kind)
            KIND_FAT12: begin
                if (!cur[0]) begin
                    new_b = (bcnt_reg == 2'd0) ? val_reg[7:0]
                          : {old_b[7:4], val_reg[11:8]};
                end else begin
                    new_b = (bcnt_reg == 2'd0) ? {val_reg[3:0], old_b[3:0]}
                          : val_reg[11:4];
                end
            end
            KIND_FAT32: begin
                if (bcnt_reg == 2'd3) new_b = {old_b[7:4], val_reg[27:24]};
            end
            default: ;
        endcase
    end

    always_comb begin
        we = 1'b0;
        waddr = byte_ptr;
        wdata = new_b;
        if (cmd.wr_issue && kind_ok) we = 1'b1;
        if (req_reg == REQ_LOAD && cmd.finish && raw_ok) begin
            we = 1'b1;
            waddr = AW'(baddr_reg);
            wdata = bdata_reg;
        end
    end

    fte_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // search bound: min(cluster_count+2, TABLE_BYTES)
    logic [28:0] bound;
    assign bound = {1'b0, cluster_count} + 29'd2;

    // cluster offset from cluster two wraps at 32 bits
    logic [31:0] sector_clus;
    assign sector_clus = {4'b0, cur} - 32'd2;
    logic [31:0] prod;
    assign prod = 32'(sector_clus * {24'b0, sectors_per_cluster});

    // result fields and next hint
    logic [27:0] res_ev, res_fc;
    logic        res_eoc;
    logic [31:0] res_ds;
    logic [7:0]  res_bo;
    logic [1:0]  res_st;
    logic [27:0] hint_next;
    always_comb begin
        res_ev = '0;
        res_eoc = 1'b0;
        res_fc = '0;
        res_ds = '0;
        res_bo = '0;
        res_st = ST_OK;
        hint_next = hint_reg;
        if (req_reg == REQ_GET || req_reg == REQ_SET) begin
            res_ds = sec_reg;
            if (!sts.in_range) begin
                res_st = ST_RANGE;
            end else begin
                res_ev = entry;
                unique case (fat_kind)
                    KIND_FAT12: res_eoc = entry >= EOC12;
                    KIND_FAT16: res_eoc = entry >= EOC16;
                    KIND_FAT32: res_eoc = entry >= EOC32;
                    default:    res_eoc = 1'b1;
                endcase
            end
        end else if (req_reg == REQ_ALLOC) begin
            if (found_reg) begin
                res_fc = clus_reg;
                res_ds = sec_reg;
                hint_next = clus_reg;
            end else begin
                res_st = ST_NO_FREE;
                if (top_reg > 28'd2) hint_next = start_reg;
            end
        end else if (req_reg == REQ_LOAD) begin
            if (!raw_ok) res_st = ST_RANGE;
        end else if (req_reg == REQ_READ) begin
            if (raw_ok) res_bo = rdata;
            else res_st = ST_RANGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hint_reg <= 28'd2;
        end else begin
            if (cmd.latch) begin
                req_reg <= s_req_type;
                idx_reg <= s_index;
                val_reg <= s_value;
                baddr_reg <= s_byte_addr;
                bdata_reg <= s_byte_data;
                found_reg <= 1'b0;
                sec_reg <= '0;
                top_reg <= (bound < 29'(TABLE_BYTES)) ? bound[27:0]
                                                       : 28'(TABLE_BYTES);
            end
            if (cmd.clr_acc) begin
                acc_reg <= '0;
                bcnt_reg <= '0;
            end
            if (cmd.alloc_init) begin
                start_reg <= (hint_reg >= 28'd2 && hint_reg < top_reg) ? hint_reg : 28'd2;
                clus_reg <= (hint_reg >= 28'd2 && hint_reg < top_reg) ? hint_reg : 28'd2;
                left_reg <= top_reg - 28'd2;
            end
            if (cmd.rd_take) acc_reg[8*bcnt_reg +: 8] <= rdata;
            if (cmd.next_byte) bcnt_reg <= bcnt_reg + 2'd1;
            if (cmd.wr_issue && !sts.last_byte) begin
                // keep byte counter moving via next_byte
            end
            if (cmd.wr_issue && sts.last_byte) bcnt_reg <= '0;
            if (cmd.rd_take && sts.last_byte && req_reg == REQ_SET) bcnt_reg <= '0;
            if (cmd.next_clus) begin
                clus_reg <= (clus_reg + 28'd1 >= top_reg) ? 28'd2 : clus_reg + 28'd1;
                left_reg <= left_reg - 28'd1;
            end
            if (cmd.mult_go) begin
                sec_reg <= prod + first_data_sector;
                found_reg <= (req_reg == REQ_ALLOC);
            end
            if (cmd.finish) begin
                m_entry_value <= res_ev;
                m_end_of_chain <= res_eoc;
                m_free_cluster <= res_fc;
                m_data_sector <= res_ds;
                m_byte_out <= res_bo;
                m_status <= res_st;
                hint_reg <= hint_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_hint_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        hint_reg >= 28'd2) else $error("hint below 2");
    a_no_write_oob: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_issue |-> sts.in_range) else $error("write outside table");
    a_clus_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.next_clus && req_reg == REQ_ALLOC) |=> clus_reg >= 28'd2)
        else $error("search cursor below 2");
`endif
endmodule
`default_nettype wire
